// ===== rtl/esd_pkg.sv =====
// ----------------------------------------------------------------------------
// esd_pkg: shared types and constants for the ESC/STX packet deframer
// Control characters, phase codes, status codes and the per-byte result.
// ----------------------------------------------------------------------------
package esd_pkg;

    localparam logic [7:0] CH_ESC = 8'h10;
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_ETB = 8'h17;

    localparam int          COUNT_W   = 17;
    localparam int          LEN_W     = 16;
    localparam int          PHASE_W   = 3;
    localparam int          STATUS_W  = 3;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] HDR_BYTES = 17'd4;

    localparam logic [PHASE_W-1:0] PH_HUNT     = 3'd0;
    localparam logic [PHASE_W-1:0] PH_START    = 3'd1;
    localparam logic [PHASE_W-1:0] PH_BODY     = 3'd2;
    localparam logic [PHASE_W-1:0] PH_BODY_ESC = 3'd3;
    localparam logic [PHASE_W-1:0] PH_CHECK    = 3'd4;
    localparam logic [PHASE_W-1:0] PH_DISCARD  = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK_LAST = 3'd0;
    localparam logic [STATUS_W-1:0] ST_OK_MORE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_SUM = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_LEN = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FRAMING = 3'd4;

    typedef struct packed {
        logic                has_result;
        logic                is_status;
        logic [7:0]          payload_byte;
        logic [STATUS_W-1:0] frame_status;
    } esd_result_t;

endpackage

// ===== rtl/esd_core.sv =====
// ----------------------------------------------------------------------------
// esd_core: frame state and per-byte decode
// Holds the phase, running XOR, stored count and header length, and turns
// one accepted byte or idle tick into at most one result.
// ----------------------------------------------------------------------------
module esd_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 take,
    input  logic                 idle_tick,
    input  logic [7:0]           rx_byte,
    input  logic                 line_error,
    output esd_pkg::esd_result_t result
);
    import esd_pkg::*;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [7:0]         xor_reg, xor_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               more_reg, more_next;

    logic               bad;
    logic               store_en;
    logic [COUNT_W-1:0] count_base;
    logic [7:0]         xor_base;
    logic [LEN_W-1:0]   len_base;

    assign bad = idle_tick | line_error;

    always_comb
    begin
        phase_next          = phase_reg;
        xor_base            = xor_reg;
        count_base          = count_reg;
        len_base            = len_reg;
        more_next           = more_reg;
        store_en            = 1'b0;
        result              = '0;

        case (phase_reg)
            PH_START:
            begin
                if (bad || rx_byte != CH_STX)
                begin
                    phase_next          = PH_DISCARD;
                    result.has_result   = 1'b1;
                    result.is_status    = 1'b1;
                    result.frame_status = ST_FRAMING;
                end
                else
                begin
                    xor_base   = '0;
                    count_base = '0;
                    len_base   = '0;
                    more_next  = 1'b0;
                    phase_next = PH_BODY;
                end
            end
            PH_BODY:
            begin
                if (bad)
                begin
                    phase_next          = PH_DISCARD;
                    result.has_result   = 1'b1;
                    result.is_status    = 1'b1;
                    result.frame_status = ST_FRAMING;
                end
                else if (rx_byte == CH_ESC)
                    phase_next = PH_BODY_ESC;
                else
                    store_en = 1'b1;
            end
            PH_BODY_ESC:
            begin
                if (bad)
                begin
                    phase_next          = PH_DISCARD;
                    result.has_result   = 1'b1;
                    result.is_status    = 1'b1;
                    result.frame_status = ST_FRAMING;
                end
                else if (rx_byte inside {CH_ETX, CH_ETB})
                begin
                    // terminator is covered by the checksum but not stored
                    xor_base   = xor_reg ^ rx_byte;
                    more_next  = (rx_byte == CH_ETB);
                    phase_next = PH_CHECK;
                end
                else
                begin
                    phase_next = PH_BODY;
                    store_en   = 1'b1;
                end
            end
            PH_CHECK:
            begin
                phase_next        = PH_HUNT;
                result.has_result = 1'b1;
                result.is_status  = 1'b1;
                if (bad || rx_byte != xor_reg)
                    result.frame_status = ST_BAD_SUM;
                else if (count_reg < HDR_BYTES
                         || {1'b0, len_reg} != count_reg - HDR_BYTES)
                    result.frame_status = ST_BAD_LEN;
                else
                    result.frame_status = more_reg ? ST_OK_MORE : ST_OK_LAST;
            end
            PH_DISCARD:
            begin
                if (idle_tick)
                    phase_next = PH_HUNT;
            end
            default:
            begin
                // hunting; unused codes land here too
                phase_next = PH_HUNT;
                if (!idle_tick)
                begin
                    if (line_error || rx_byte != CH_ESC)
                    begin
                        phase_next          = PH_DISCARD;
                        result.has_result   = 1'b1;
                        result.is_status    = 1'b1;
                        result.frame_status = ST_FRAMING;
                    end
                    else
                        phase_next = PH_START;
                end
            end
        endcase

        xor_next   = xor_base;
        count_next = count_base;
        len_next   = len_base;
        if (store_en)
        begin
            xor_next = xor_reg ^ rx_byte;
            if (count_reg == 17'd2)
                len_next = {len_reg[15:8], rx_byte};
            else if (count_reg == 17'd3)
                len_next = {rx_byte, len_reg[7:0]};
            else if (count_reg >= HDR_BYTES)
            begin
                result.has_result   = 1'b1;
                result.is_status    = 1'b0;
                result.payload_byte = rx_byte;
            end
            if (count_reg != COUNT_MAX)
                count_next = count_reg + 17'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            xor_reg   <= '0;
            count_reg <= '0;
            len_reg   <= '0;
            more_reg  <= 1'b0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            xor_reg   <= xor_next;
            count_reg <= count_next;
            len_reg   <= len_next;
            more_reg  <= more_next;
        end
    end

    a_check_returns_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        take && phase_reg == PH_CHECK |=> phase_reg == PH_HUNT)
        else $error("phase did not return to hunting after checksum slot");

    a_check_gives_status: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_CHECK |-> result.has_result && result.is_status)
        else $error("checksum slot produced no status");

endmodule

// ===== rtl/esc_stx_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// esc_stx_packet_deframer: ESC/STX byte-stuffed frame receiver
// Unstuffs frames, checks XOR checksum and header length, emits payload.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one request per received byte
//   (rx_byte, line_error) or per receive timeout (idle_tick = 1).
//   Output channel (out_valid/out_ready): payload bytes past the 4-byte
//   header, each as is_status = 0, then one status per frame with
//   is_status = 1 and frame_status giving ok/more, checksum, length or
//   framing error. Requests that finish nothing give no output.
//   An accepted request's result is in the output register in the next
//   cycle. Throughput is one request per cycle; the limit is the
//   single output register, so in_ready drops only while a result waits
//   and out_ready is low. A stalled receiver holds the result and the
//   frame state; nothing is dropped.
//   Reset puts the block in the hunting phase with an empty output.
// ----------------------------------------------------------------------------
module esc_stx_packet_deframer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          idle_tick,
    input  logic [7:0]                    rx_byte,
    input  logic                          line_error,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          is_status,
    output logic [7:0]                    payload_byte,
    output logic [esd_pkg::STATUS_W-1:0]  frame_status
);
    import esd_pkg::*;

    esd_result_t         result;
    logic                take;
    logic                valid_reg, valid_next;
    logic                is_status_reg;
    logic [7:0]          payload_reg;
    logic [STATUS_W-1:0] status_reg;

    assign in_ready = !valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    esd_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .idle_tick  (idle_tick),
        .rx_byte    (rx_byte),
        .line_error (line_error),
        .result     (result)
    );

    assign valid_next = take ? result.has_result : (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take && result.has_result)
        begin
            is_status_reg <= result.is_status;
            payload_reg   <= result.payload_byte;
            status_reg    <= result.frame_status;
        end
    end

    assign out_valid    = valid_reg;
    assign is_status    = is_status_reg;
    assign payload_byte = payload_reg;
    assign frame_status = status_reg;

    a_status_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && is_status_reg |-> payload_reg == 8'h00)
        else $error("status result carries a payload byte");

    a_payload_zero_status: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !is_status_reg |-> status_reg == ST_OK_LAST)
        else $error("payload result carries a status code");

    a_stall_only: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> valid_reg && !out_ready)
        else $error("input stalled without a waiting result");

endmodule
